### sv/tmcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmcs_pkg
// Shared constants and types for the tiny memory CPU step engine.
// ----------------------------------------------------------------------------
package tmcs_pkg;

  localparam int ADDR_BITS_DEF = 16;

  // Commands carried in the input tuser.
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;

  // Event codes carried in the output tuser.
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_OUT  = 2'd1;
  localparam logic [1:0] EV_HALT = 2'd2;

  // Opcodes in the low nibble of an instruction.
  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_MOVI = 4'd1;
  localparam logic [3:0] OP_OUT  = 4'd2;
  localparam logic [3:0] OP_BANK = 4'd3;

  localparam logic [3:0] EXIT_OP_RESET = 4'hF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH_HI,
    ST_DECODE,
    ST_A_HI,
    ST_A_DONE,
    ST_B_HI,
    ST_B_DONE,
    ST_WRITE_HI,
    ST_HOLD
  } state_t;

endpackage
`default_nettype wire

### sv/tmcs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmcs_ram
// Single-port byte memory with a registered read, shared by program and data.
// ----------------------------------------------------------------------------
module tmcs_ram #(
  parameter int ADDR_BITS = tmcs_pkg::ADDR_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] addr,
  input  wire logic [7:0]           wdata,
  output logic      [7:0]           rdata
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

### sv/tiny_memory_cpu_step.sv
`timescale 1ns / 1ps
`default_nettype none
// Load, start and a step while halted finish in the accept cycle. A step fetches the
// instruction and ends at decode for exit, movi, bank and no-op, after reading a for
// out, and after writing a+b to a for add. The result is registered and waits in a
// pending slot while the output is full. The single byte-wide memory port lets in
// one item at a time. Reset: halted, ip and bank base zero, exit opcode 15; the memory
// is not cleared.
// ----------------------------------------------------------------------------
// tiny_memory_cpu_step
// Sequencer of a tiny CPU that reads, modifies and writes a shared byte memory.
// ----------------------------------------------------------------------------
module tiny_memory_cpu_step #(
  parameter int ADDR_BITS = tmcs_pkg::ADDR_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data,       // exit_opcode
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // address [15:0], byte_value [23:16]
  input  wire logic [1:0]  s_axis_tuser,   // command [1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // out_address [15:0], out_word [31:16]
  output logic [1:0]       m_axis_tuser    // event_res [1:0]
);

  tmcs_pkg::state_t state, state_next;

  logic [ADDR_BITS-1:0] ip;
  logic [15:0]          bank;
  logic                 halted;
  logic [3:0]           exit_op;

  logic [7:0]           instr_lo;
  logic [ADDR_BITS-1:0] a_addr;
  logic [ADDR_BITS-1:0] b_addr;
  logic [7:0]           lo_byte;
  logic [15:0]          x;
  logic [7:0]           sum_hi;

  logic                 out_valid;
  logic [1:0]           out_event;
  logic [15:0]          out_addr;
  logic [15:0]          out_word;
  logic [1:0]           pend_event;
  logic [15:0]          pend_addr;
  logic [15:0]          pend_word;

  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_addr;
  logic [7:0]           mem_wdata;
  logic [7:0]           rdata;

  logic                 fin;
  logic [1:0]           res_event;
  logic [15:0]          res_addr;
  logic [15:0]          res_word;

  logic                 in_fire;
  logic                 out_free;
  logic                 load_out;
  logic [1:0]           cmd;
  logic [ADDR_BITS-1:0] in_addr;
  logic [7:0]           in_byte;
  logic [3:0]           opc;
  logic                 is_exit;
  logic [ADDR_BITS-1:0] a_dec;
  logic [ADDR_BITS-1:0] b_dec;
  logic [15:0]          sum;
  logic [ADDR_BITS-1:0] ip_step;

  assign cmd     = s_axis_tuser;
  assign in_addr = ADDR_BITS'(s_axis_tdata[15:0]);
  assign in_byte = s_axis_tdata[23:16];

  assign s_axis_tready = (state == tmcs_pkg::ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign load_out      = out_free && (fin || state == tmcs_pkg::ST_HOLD);

  // The opcode and operand a sit in the low byte; b sits in the high byte,
  // which is on the read port while decoding.
  assign opc     = instr_lo[3:0];
  assign is_exit = (opc == exit_op);
  assign a_dec   = ADDR_BITS'({bank[15:4], instr_lo[7:4]});
  assign b_dec   = ADDR_BITS'({bank[15:4], rdata[3:0]});
  assign sum     = x + {rdata, lo_byte};
  assign ip_step = ip + ADDR_BITS'(2);

  assign cfg_ready = 1'b1;

  tmcs_ram #(
    .ADDR_BITS(ADDR_BITS)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      tmcs_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (cmd == tmcs_pkg::CMD_STEP && !halted) begin
            state_next = tmcs_pkg::ST_FETCH_HI;
          end else if (!out_free) begin
            state_next = tmcs_pkg::ST_HOLD;
          end
        end
      end
      tmcs_pkg::ST_FETCH_HI: state_next = tmcs_pkg::ST_DECODE;
      tmcs_pkg::ST_DECODE: begin
        if (!is_exit && (opc == tmcs_pkg::OP_ADD || opc == tmcs_pkg::OP_OUT)) begin
          state_next = tmcs_pkg::ST_A_HI;
        end else begin
          state_next = out_free ? tmcs_pkg::ST_IDLE : tmcs_pkg::ST_HOLD;
        end
      end
      tmcs_pkg::ST_A_HI: state_next = tmcs_pkg::ST_A_DONE;
      tmcs_pkg::ST_A_DONE: begin
        if (opc == tmcs_pkg::OP_OUT) begin
          state_next = out_free ? tmcs_pkg::ST_IDLE : tmcs_pkg::ST_HOLD;
        end else begin
          state_next = tmcs_pkg::ST_B_HI;
        end
      end
      tmcs_pkg::ST_B_HI:     state_next = tmcs_pkg::ST_B_DONE;
      tmcs_pkg::ST_B_DONE:   state_next = tmcs_pkg::ST_WRITE_HI;
      tmcs_pkg::ST_WRITE_HI: state_next = out_free ? tmcs_pkg::ST_IDLE : tmcs_pkg::ST_HOLD;
      tmcs_pkg::ST_HOLD:     state_next = out_free ? tmcs_pkg::ST_IDLE : tmcs_pkg::ST_HOLD;
      default:               state_next = tmcs_pkg::ST_IDLE;
    endcase
  end

  // Memory port control and the finished result.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = ip;
    mem_wdata = in_byte;
    fin       = 1'b0;
    res_event = tmcs_pkg::EV_NONE;
    res_addr  = 16'd0;
    res_word  = 16'd0;
    case (state)
      tmcs_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (cmd)
            tmcs_pkg::CMD_LOAD: begin
              mem_we   = 1'b1;
              mem_addr = in_addr;
              fin      = 1'b1;
            end
            tmcs_pkg::CMD_STEP: begin
              if (halted) begin
                fin       = 1'b1;
                res_event = tmcs_pkg::EV_HALT;
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end
      tmcs_pkg::ST_FETCH_HI: mem_addr = ip + ADDR_BITS'(1);
      tmcs_pkg::ST_DECODE: begin
        if (is_exit) begin
          fin       = 1'b1;
          res_event = tmcs_pkg::EV_HALT;
        end else begin
          case (opc)
            tmcs_pkg::OP_ADD:  mem_addr = a_dec;
            tmcs_pkg::OP_OUT:  mem_addr = a_dec;
            tmcs_pkg::OP_MOVI: begin
              mem_we    = 1'b1;
              mem_addr  = a_dec;
              mem_wdata = rdata;
              fin       = 1'b1;
            end
            default: fin = 1'b1;
          endcase
        end
      end
      tmcs_pkg::ST_A_HI: mem_addr = a_addr + ADDR_BITS'(1);
      tmcs_pkg::ST_A_DONE: begin
        if (opc == tmcs_pkg::OP_OUT) begin
          fin       = 1'b1;
          res_event = tmcs_pkg::EV_OUT;
          res_addr  = 16'(a_addr);
          res_word  = {rdata, lo_byte};
        end else begin
          mem_addr = b_addr;
        end
      end
      tmcs_pkg::ST_B_HI: mem_addr = b_addr + ADDR_BITS'(1);
      tmcs_pkg::ST_B_DONE: begin
        mem_we    = 1'b1;
        mem_addr  = a_addr;
        mem_wdata = sum[7:0];
      end
      tmcs_pkg::ST_WRITE_HI: begin
        mem_we    = 1'b1;
        mem_addr  = a_addr + ADDR_BITS'(1);
        mem_wdata = sum_hi;
        fin       = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= tmcs_pkg::ST_IDLE;
      ip      <= '0;
      bank    <= 16'd0;
      halted  <= 1'b1;
      exit_op <= tmcs_pkg::EXIT_OP_RESET;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        exit_op <= cfg_data;
      end
      case (state)
        tmcs_pkg::ST_IDLE: begin
          if (in_fire && cmd == tmcs_pkg::CMD_START) begin
            ip     <= in_addr;
            halted <= 1'b0;
          end
        end
        tmcs_pkg::ST_DECODE: begin
          if (is_exit) begin
            halted <= 1'b1;
          end else if (opc != tmcs_pkg::OP_ADD && opc != tmcs_pkg::OP_OUT) begin
            ip <= ip_step;
            if (opc == tmcs_pkg::OP_BANK) begin
              bank <= {rdata, instr_lo[7:4], 4'd0};
            end
          end
        end
        tmcs_pkg::ST_A_DONE: begin
          if (opc == tmcs_pkg::OP_OUT) begin
            ip <= ip_step;
          end
        end
        tmcs_pkg::ST_WRITE_HI: ip <= ip_step;
        default: ;
      endcase
    end
  end

  // Operand and partial-word registers.
  always_ff @(posedge clk) begin
    case (state)
      tmcs_pkg::ST_FETCH_HI: instr_lo <= rdata;
      tmcs_pkg::ST_DECODE: begin
        a_addr <= a_dec;
        b_addr <= b_dec;
      end
      tmcs_pkg::ST_A_HI:   lo_byte <= rdata;
      tmcs_pkg::ST_A_DONE: x       <= {rdata, lo_byte};
      tmcs_pkg::ST_B_HI:   lo_byte <= rdata;
      tmcs_pkg::ST_B_DONE: sum_hi  <= sum[15:8];
      default: ;
    endcase
  end

  // Output register, with a pending slot so that work goes on while a word waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (state == tmcs_pkg::ST_HOLD) begin
        out_event <= pend_event;
        out_addr  <= pend_addr;
        out_word  <= pend_word;
      end else begin
        out_event <= res_event;
        out_addr  <= res_addr;
        out_word  <= res_word;
      end
    end
    if (fin && !out_free) begin
      pend_event <= res_event;
      pend_addr  <= res_addr;
      pend_word  <= res_word;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_event;
  assign m_axis_tdata  = {out_word, out_addr};

endmodule
`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the tiny memory CPU step engine against a cycle-free mirror of its
// state. Command words mix directed programs, random programs and noise. Both
// stream sides idle at random, and the exit opcode changes between phases.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_WORDS = 150;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [15:0] out_address;
    logic [15:0] out_word;
  } cpu_event_t;

  // Mirrors memory, instruction pointer, bank and halt state, and keeps the
  // events that the block still owes.
  class tiny_cpu_mirror;
    bit [7:0]   mem [0:65535];
    bit         written [0:65535];
    bit [15:0]  ip;
    bit [15:0]  bank;
    bit         halted;
    bit [3:0]   exit_op;
    cpu_event_t owed_events [$];
    int         fails;
    int         executed;
    int         reports;
    int         halts;

    function new();
      ip = '0;
      bank = '0;
      halted = 1'b1;
      exit_op = tmcs_pkg::EXIT_OP_RESET;
    endfunction

    function bit [15:0] word_at(bit [15:0] a);
      bit [15:0] a1;
      a1 = a + 16'd1;
      return {mem[a1], mem[a]};
    endfunction

    function void put_byte(bit [15:0] a, bit [7:0] v);
      mem[a] = v;
      written[a] = 1'b1;
    endfunction

    function bit word_has_hole(bit [15:0] a, output bit [15:0] where);
      bit [15:0] a1;
      a1 = a + 16'd1;
      where = a;
      if (!written[a]) return 1'b1;
      where = a1;
      return !written[a1];
    endfunction

    // Finds a byte that the next step would read before anything wrote it.
    function bit step_needs_load(output bit [15:0] where);
      bit [15:0] instr;
      bit [15:0] pa;
      bit [15:0] pb;
      where = '0;
      if (halted) return 1'b0;
      if (word_has_hole(ip, where)) return 1'b1;
      instr = word_at(ip);
      pa = bank | {12'd0, instr[7:4]};
      pb = bank | {12'd0, instr[11:8]};
      if (instr[3:0] == exit_op) return 1'b0;
      if (instr[3:0] == tmcs_pkg::OP_ADD) begin
        if (word_has_hole(pa, where)) return 1'b1;
        return word_has_hole(pb, where);
      end
      if (instr[3:0] == tmcs_pkg::OP_OUT) return word_has_hole(pa, where);
      return 1'b0;
    endfunction

    function void accept_item(bit [1:0] cmd, bit [15:0] addr, bit [7:0] val);
      cpu_event_t ev;
      bit [15:0]  instr;
      bit [15:0]  pa;
      bit [15:0]  pb;
      bit [15:0]  sum;
      ev = '0;
      if (cmd == tmcs_pkg::CMD_LOAD) begin
        put_byte(addr, val);
      end else if (cmd == tmcs_pkg::CMD_START) begin
        ip = addr;
        halted = 1'b0;
      end else if (cmd == tmcs_pkg::CMD_STEP) begin
        if (halted) begin
          ev.event_res = tmcs_pkg::EV_HALT;
        end else begin
          instr = word_at(ip);
          pa = bank | {12'd0, instr[7:4]};
          pb = bank | {12'd0, instr[11:8]};
          executed++;
          // The exit opcode wins even when it shadows a defined opcode.
          if (instr[3:0] == exit_op) begin
            halted = 1'b1;
            ev.event_res = tmcs_pkg::EV_HALT;
          end else begin
            case (instr[3:0])
              tmcs_pkg::OP_ADD: begin
                sum = word_at(pa) + word_at(pb);
                put_byte(pa, sum[7:0]);
                put_byte(pa + 16'd1, sum[15:8]);
              end
              tmcs_pkg::OP_MOVI: put_byte(pa, instr[15:8]);
              tmcs_pkg::OP_OUT: begin
                ev.event_res = tmcs_pkg::EV_OUT;
                ev.out_address = pa;
                ev.out_word = word_at(pa);
              end
              tmcs_pkg::OP_BANK: bank = {instr[15:4], 4'd0};
              default: ;
            endcase
            ip = ip + 16'd2;
          end
        end
      end
      if (ev.event_res == tmcs_pkg::EV_OUT) reports++;
      if (ev.event_res == tmcs_pkg::EV_HALT) halts++;
      owed_events.push_back(ev);
    endfunction

    function void check_event(logic [1:0] ev_res, logic [15:0] oaddr, logic [15:0] oword);
      cpu_event_t exp_ev;
      if (owed_events.size() == 0) begin
        $error("result word with no command word waiting: event_res %0d", ev_res);
        fails++;
        return;
      end
      exp_ev = owed_events.pop_front();
      if (ev_res !== exp_ev.event_res) begin
        $error("event_res: expected %0d, got %0d", exp_ev.event_res, ev_res);
        fails++;
      end
      if (oaddr !== exp_ev.out_address) begin
        $error("out_address: expected %h, got %h", exp_ev.out_address, oaddr);
        fails++;
      end
      if (oword !== exp_ev.out_word) begin
        $error("out_word: expected %h, got %h", exp_ev.out_word, oword);
        fails++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  tiny_cpu_mirror mirror;
  int         cycle_count = 0;
  int         words_sent = 0;
  int         results_seen = 0;
  int         exit_settings = 0;
  int         tx_calm_left = 0;
  int         rx_calm_left = 0;
  bit         long_hold_done = 1'b0;
  bit [15:0]  bank_pool [0:2];

  tiny_memory_cpu_step u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Draws a random wait, with occasional stretches of no waiting.
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(10, 40);
    return $urandom_range(0, 17);
  endfunction

  task automatic send_word(input bit [1:0] cmd, input bit [15:0] addr, input bit [7:0] val);
    int gap;
    gap = draw_wait(tx_calm_left);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {val, addr};
    s_axis_tuser <= cmd;
    @(posedge clk);
    while (s_axis_tready !== 1'b1) @(posedge clk);
    mirror.accept_item(cmd, addr, val);
    if (cmd != CMD_UNUSED) words_sent++;
  endtask

  task automatic load_half(input bit [15:0] addr, input bit [15:0] value);
    send_word(tmcs_pkg::CMD_LOAD, addr, value[7:0]);
    send_word(tmcs_pkg::CMD_LOAD, addr + 16'd1, value[15:8]);
  endtask

  // Fills any byte the step would read before it was ever written.
  task automatic step_cpu();
    bit [15:0] hole;
    while (mirror.step_needs_load(hole))
      send_word(tmcs_pkg::CMD_LOAD, hole, 8'($urandom_range(0, 255)));
    send_word(tmcs_pkg::CMD_STEP, 16'($urandom_range(0, 65535)),
              8'($urandom_range(0, 255)));
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (mirror.owed_events.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_exit_opcode(input bit [3:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    mirror.exit_op = value;
    exit_settings++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic bit [15:0] pick_instr(bit last);
    bit [15:0] w;
    w = 16'($urandom_range(0, 65535));
    if (last) begin
      w[3:0] = mirror.exit_op;
      return w;
    end
    case ($urandom_range(0, 9))
      0, 1: w[3:0] = tmcs_pkg::OP_ADD;
      2, 3: w[3:0] = tmcs_pkg::OP_MOVI;
      4, 5: w[3:0] = tmcs_pkg::OP_OUT;
      6: begin
        w[3:0] = tmcs_pkg::OP_BANK;
        // Mostly reuse a few banks so that data written earlier is read again.
        if ($urandom_range(0, 3) != 0) w[15:4] = bank_pool[$urandom_range(0, 2)][15:4];
      end
      7: w[3:0] = mirror.exit_op;
      default: w[3:0] = 4'($urandom_range(4, 15));
    endcase
    return w;
  endfunction

  task automatic run_program();
    int        n;
    bit [15:0] base;
    bit [15:0] pc;
    bit        with_start;
    bit        with_exit;
    n = $urandom_range(3, 10);
    with_start = ($urandom_range(0, 7) != 0);
    with_exit = ($urandom_range(0, 3) != 0);
    base = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 7) == 0) base = 16'hFFFA;
    pc = base;
    for (int k = 0; k < n; k++) begin
      load_half(pc, pick_instr(with_exit && k == n - 1));
      pc = pc + 16'd2;
    end
    if (with_start) send_word(tmcs_pkg::CMD_START, base, 8'($urandom_range(0, 255)));
    repeat (n + $urandom_range(0, 2)) step_cpu();
  endtask

  task automatic run_noise();
    int sel;
    repeat ($urandom_range(4, 10)) begin
      sel = $urandom_range(0, 19);
      if (sel < 8)
        send_word(tmcs_pkg::CMD_LOAD, 16'($urandom_range(0, 65535)),
                  8'($urandom_range(0, 255)));
      else if (sel < 11)
        send_word(tmcs_pkg::CMD_START, 16'($urandom_range(0, 65535)),
                  8'($urandom_range(0, 255)));
      else if (sel < 19)
        step_cpu();
      else
        send_word(CMD_UNUSED, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
    end
  endtask

  // Result side: random hold-offs, plus one long stall that backs up the input.
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (!long_hold_done && results_seen >= 400) begin
        gap = 300;
        long_hold_done = 1'b1;
      end else begin
        gap = draw_wait(rx_calm_left);
      end
      @(negedge clk);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (m_axis_tvalid !== 1'b1) @(posedge clk);
      mirror.check_event(m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16]);
      results_seen++;
    end
  end

  initial begin
    bit [15:0] demo [0:7];
    bit [3:0]  settings [0:7];
    bit [15:0] pc;
    int        target;
    mirror = new();
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    bank_pool[0] = 16'h4000;
    bank_pool[1] = 16'hFFF0;
    bank_pool[2] = 16'($urandom_range(0, 65535)) & 16'hFFF0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed program placed at the top of memory so that ip wraps to zero:
    // bank, movi, add with 16-bit wrap, out, a no-op, a bank at the top of the
    // space, an out whose word straddles the wrap, and exit.
    demo = '{16'h1233, 16'hFFF1, 16'h0640, 16'h0042,
             16'hABC9, 16'hFFF3, 16'h00F2, 16'h000F};
    send_word(tmcs_pkg::CMD_STEP, 16'hFFFF, 8'hFF);
    send_word(CMD_UNUSED, 16'hFFFF, 8'hFF);
    load_half(16'h1234, 16'hFFFF);
    load_half(16'h1236, 16'h0001);
    pc = 16'hFFFE;
    for (int k = 0; k < 8; k++) begin
      load_half(pc, demo[k]);
      pc = pc + 16'd2;
    end
    send_word(tmcs_pkg::CMD_START, 16'hFFFE, 8'h00);
    repeat (9) step_cpu();
    drain();

    // Exit opcode settings, including values that shadow add, movi, out, bank.
    settings = '{4'h0, 4'h2, 4'hF, 4'h3, 4'h1, 4'h7, 4'($urandom_range(0, 15)), 4'hA};
    for (int p = 0; p < 8; p++) begin
      write_exit_opcode(settings[p]);
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) begin
        if ($urandom_range(0, 9) < 7) run_program();
        else run_noise();
      end
      drain();
    end

    $display("Run covered %0d command words: %0d executed instructions, %0d out reports, %0d halts.",
             words_sent, mirror.executed, mirror.reports, mirror.halts);
    $display("Exit opcode was written %0d times; one long output stall backed up the input.",
             exit_settings);
    if (mirror.fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
